/* hdl/swpd_pkg.sv */
// ----------------------------------------------------------------------------
// swpd_pkg
// Types shared by the sliding-window peak detector files.
// ----------------------------------------------------------------------------
`default_nettype none

package swpd_pkg;

    localparam int SAMPLE_W = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Control handed from the top level to every window cell.
    typedef struct packed {
        logic    shift;   // window advances this cycle
        t_sample centre;  // centre value after the advance
    } t_cell_ctl;

endpackage

`default_nettype wire

/* hdl/swpd_if.sv */
// ----------------------------------------------------------------------------
// swpd_if
// Valid/ready channels of the peak detector: samples, results, threshold.
// ----------------------------------------------------------------------------
`default_nettype none

interface swpd_in_if;
    logic              valid;
    logic              ready;
    swpd_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swpd_out_if;
    logic              valid;
    logic              ready;
    logic              peak_flag;
    swpd_pkg::t_sample centre_value;

    modport source (output valid, output peak_flag, output centre_value, input ready);
    modport sink   (input valid, input peak_flag, input centre_value, output ready);
endinterface

interface swpd_cfg_if;
    logic              valid;
    logic              ready;
    swpd_pkg::t_sample data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/sliding_window_peak_detector.sv */
// ----------------------------------------------------------------------------
// sliding_window_peak_detector
// Flags the centre of a 2*HALF_WIDTH+1 sample window as a peak when it is
// above the threshold and no window sample is greater.
// ----------------------------------------------------------------------------
// One sample is taken per clock whenever the result register is empty or
// being drained, so the sustained rate is one sample per cycle; the result
// for a sample is registered when the sample HALF_WIDTH places later is
// accepted. The window is a row of cells that all shift together on an
// accepted request; each cell compares its incoming value against the new
// centre, and the flags are OR-reduced into the registered result. The
// first HALF_WIDTH samples after reset give no result, and the window's
// reset zeros count as samples. The threshold port is always ready and
// should only be written while no result is pending.
`default_nettype none

module sliding_window_peak_detector #(
    parameter int HALF_WIDTH = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    swpd_in_if.sink    i_sample_ch,
    swpd_cfg_if.sink   i_cfg,
    swpd_out_if.source o_result_ch
);

    localparam int WIN_LEN = 2 * HALF_WIDTH + 1;
    localparam int CNT_W   = $clog2(HALF_WIDTH + 1);
    localparam logic [CNT_W-1:0] WARM = CNT_W'(HALF_WIDTH);

    swpd_pkg::t_sample   r_threshold;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_valid;
    logic                r_flag;
    swpd_pkg::t_sample   r_centre;

    logic                accept;
    logic                warm;
    swpd_pkg::t_cell_ctl ctl;
    swpd_pkg::t_sample   cell_value [WIN_LEN];
    logic [WIN_LEN-1:0]  cell_gt;
    logic                n_flag;

    assign i_sample_ch.ready = !r_valid || o_result_ch.ready;
    assign accept            = i_sample_ch.valid && i_sample_ch.ready;
    assign warm              = r_cnt == WARM;
    assign i_cfg.ready       = 1'b1;

    // After the shift the centre is the sample now one place newer.
    assign ctl.shift  = accept;
    assign ctl.centre = cell_value[HALF_WIDTH+1];

    for (genvar g = 0; g < WIN_LEN; g++) begin : g_cell
        swpd_pkg::t_sample next_in;
        if (g == WIN_LEN - 1) begin : g_last
            assign next_in = i_sample_ch.sample;
        end else begin : g_mid
            assign next_in = cell_value[g+1];
        end
        swpd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_next  (next_in),
            .o_value (cell_value[g]),
            .o_gt    (cell_gt[g])
        );
    end

    assign n_flag = (ctl.centre > r_threshold) && !(|cell_gt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_cnt       <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_threshold <= i_cfg.data;
            end
            if (accept && !warm) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (accept) begin
                r_valid <= warm;
            end else if (o_result_ch.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flag   <= n_flag;
            r_centre <= ctl.centre;
        end
    end

    assign o_result_ch.valid        = r_valid;
    assign o_result_ch.peak_flag    = r_flag;
    assign o_result_ch.centre_value = r_centre;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= WARM)
        else $error("warm-up count past half width");

    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_result_ch.ready) |-> !i_sample_ch.ready)
        else $error("sample taken while result stalled");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(accept) && $past(warm))
        else $error("result without a warm accepted sample");

endmodule

`default_nettype wire

/* hdl/swpd_cell.sv */
// ----------------------------------------------------------------------------
// swpd_cell
// One window position: holds a sample, takes its neighbor's on a shift and
// flags when the value it takes beats the new window centre.
// ----------------------------------------------------------------------------
`default_nettype none

module swpd_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire swpd_pkg::t_cell_ctl i_ctl,
    input  wire swpd_pkg::t_sample   i_next,   // value from the newer neighbor
    output swpd_pkg::t_sample        o_value,
    output logic                     o_gt
);

    swpd_pkg::t_sample r_value;
    swpd_pkg::t_sample n_value;

    always_comb begin
        n_value = i_ctl.shift ? i_next : r_value;
    end

    // Window starts as zeros, and those zeros take part in the compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
    assign o_gt    = i_next > i_ctl.centre;

endmodule

`default_nettype wire
